[design/npc_pkg.sv]
// Shared constants and types for the nearest palette color search.
package npc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

	localparam int COMP_W = 8;
	localparam int INDEX_W = 8;
	localparam int SQ_W = 2 * COMP_W;
	// 10 * 255^2 fits in 20 bits; the starting best, twice the distance to black, takes one more
	localparam int DIST_W = 20;
	localparam int BEST_W = DIST_W + 1;

	localparam int WEIGHT_RED = 3;
	localparam int WEIGHT_GREEN = 5;
	localparam int WEIGHT_BLUE = 2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} color_t;

	localparam int COLOR_W = $bits(color_t);

endpackage

[design/nearest_palette_color.sv]
// Nearest palette color search: palette RAM, scan sequencer and best tracker.
// A write beat gives no result.
// A query beat scans entries 0 upward, one RAM read per cycle, and raises its
// result once the last entry is compared and the output is free (sooner on an exact hit).
// The block takes no new beat, write or query, until the current query has raised its result.
// Reset clears control and the output valid; palette contents stay undefined.
module nearest_palette_color
	import npc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [COMP_W-1:0]  red,
	input  logic [COMP_W-1:0]  green,
	input  logic [COMP_W-1:0]  blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [INDEX_W-1:0] best_index,
	output logic               exact_match
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	color_t            query_q;

	logic              v_s1, v_s2, v_s3;
	logic              seed_s1, seed_s2, seed_s3;
	logic [ADDR_W-1:0] idx_s1, idx_s2, idx_s3;

	logic [BEST_W-1:0] best_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic              replaced_q;
	logic              d0zero_q;

	logic              out_valid_q;
	logic [INDEX_W-1:0] best_index_q;
	logic              exact_q;

	logic              accept, wr_beat, q_beat, wr_en;
	logic [ADDR_W-1:0] waddr;
	logic              issue;
	logic [ADDR_W-1:0] raddr;
	logic [COLOR_W-1:0] rdata;
	color_t            entry_s1;
	logic [DIST_W-1:0] dist_s3;
	logic              cmp_s3, less, hit, done;
	logic              out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign wr_beat  = accept && (mode == MODE_WRITE);
	assign q_beat   = accept && (mode == MODE_QUERY);
	assign wr_en    = wr_beat && (32'(entry_index) < PALETTE_ENTRIES);
	assign waddr    = ADDR_W'(entry_index);

	assign issue = (state_q == ST_SCAN) && (cnt_q < CNT_W'(PALETTE_ENTRIES));
	assign raddr = cnt_q[ADDR_W-1:0];

	npc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ({red, green, blue}),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// seed beat measures the distance to black
	assign entry_s1 = seed_s1 ? '0 : color_t'(rdata);

	npc_dist u_dist (
		.clk      (clk),
		.query    (query_q),
		.entry    (entry_s1),
		.distance (dist_s3)
	);

	always_comb begin
		cmp_s3 = (state_q == ST_SCAN) && v_s3 && !seed_s3;
		less   = ({1'b0, dist_s3} < best_q);
		hit    = cmp_s3 && less && (dist_s3 == '0);
		done   = hit || (cmp_s3 && (idx_s3 == LAST_ADDR));
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= q_beat || (issue && !done);
			v_s2 <= v_s1 && (state_q == ST_SCAN) && !done;
			v_s3 <= v_s2 && (state_q == ST_SCAN) && !done;
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_beat) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: query, stage tags, best tracker, result
	always_ff @(posedge clk) begin
		if (q_beat) begin
			query_q    <= '{red: red, green: green, blue: blue};
			replaced_q <= 1'b0;
		end
		seed_s1 <= q_beat;
		idx_s1  <= raddr;
		seed_s2 <= seed_s1;
		idx_s2  <= idx_s1;
		seed_s3 <= seed_s2;
		idx_s3  <= idx_s2;

		if ((state_q == ST_SCAN) && v_s3 && seed_s3) begin
			best_q     <= {dist_s3, 1'b0};
			best_idx_q <= '0;
		end
		if (cmp_s3) begin
			if (idx_s3 == '0) begin
				d0zero_q <= (dist_s3 == '0);
			end
			if (less) begin
				best_q     <= BEST_W'(dist_s3);
				best_idx_q <= idx_s3;
				replaced_q <= 1'b1;
			end
		end

		if ((state_q == ST_FINISH) && out_free) begin
			best_index_q <= INDEX_W'(best_idx_q);
			exact_q      <= replaced_q ? (best_q == '0) : d0zero_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign best_index  = best_index_q;
	assign exact_match = exact_q;

`ifndef SYNTHESIS
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_scan_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(PALETTE_ENTRIES)))
		else $error("scan counter overran the palette");

	a_compare_behind_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_s3 |-> (32'(idx_s3) < 32'(cnt_q)))
		else $error("compared entry was never issued");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (state_q == ST_SCAN)) |=> !(state_q == ST_IDLE))
		else $error("scan left without finish");
`endif

endmodule

[design/npc_ram.sv]
// Generic simple dual-port RAM with registered read data.
module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/npc_dist.sv]
// Two-stage weighted squared distance: squares, then weighted sum.
module npc_dist
	import npc_pkg::*;
(
	input  logic              clk,
	input  color_t            query,
	input  color_t            entry,
	output logic [DIST_W-1:0] distance
);

	logic [COMP_W-1:0] dr, dg, db;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] dist_s3;

	always_comb begin
		dr = (query.red > entry.red) ? query.red - entry.red : entry.red - query.red;
		dg = (query.green > entry.green) ? query.green - entry.green
		                                 : entry.green - query.green;
		db = (query.blue > entry.blue) ? query.blue - entry.blue : entry.blue - query.blue;
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		dist_s3 <= DIST_W'(sq_r_s2) * DIST_W'(WEIGHT_RED)
		         + DIST_W'(sq_g_s2) * DIST_W'(WEIGHT_GREEN)
		         + DIST_W'(sq_b_s2) * DIST_W'(WEIGHT_BLUE);
	end

	assign distance = dist_s3;

endmodule

[dv/palette_match_monitor.sv]
// Watches both channels of the palette search, predicts each query answer and compares.
`timescale 1ns / 1ps
module palette_match_monitor
	import npc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               mode,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [COMP_W-1:0]  red,
	input  logic [COMP_W-1:0]  green,
	input  logic [COMP_W-1:0]  blue,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [INDEX_W-1:0] best_index,
	input  logic               exact_match,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               exact;
	} match_t;

	color_t palette_copy [PALETTE_ENTRIES];
	match_t awaited_matches [$];

	function automatic logic [DIST_W-1:0] weighted_dist(color_t a, color_t b);
		int dr, dg, db;
		dr = int'(a.red) - int'(b.red);
		dg = int'(a.green) - int'(b.green);
		db = int'(a.blue) - int'(b.blue);
		return DIST_W'(WEIGHT_RED * dr * dr + WEIGHT_GREEN * dg * dg + WEIGHT_BLUE * db * db);
	endfunction

	function automatic match_t nearest_match(color_t q);
		logic [BEST_W-1:0] best_dist;
		logic [DIST_W-1:0] d;
		int best;
		match_t m;
		// running best starts at twice the distance to black, fallback entry 0
		best_dist = BEST_W'(2 * weighted_dist(q, '0));
		best = 0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			d = weighted_dist(q, palette_copy[i]);
			if (BEST_W'(d) < best_dist) begin
				best_dist = BEST_W'(d);
				best = i;
				if (d == '0)
					break;
			end
		end
		m.index = INDEX_W'(best);
		m.exact = (weighted_dist(q, palette_copy[best]) == '0);
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_t want;
		color_t c;
		if (!arst_n) begin
			awaited_matches.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result side first: a beat taken at this edge cannot answer itself
			if (out_valid && !out_stall) begin
				if (awaited_matches.size() == 0) begin
					$display("%0t: unexpected result best_index %0d exact_match %0d",
						$time, best_index, exact_match);
					fail_count++;
				end else begin
					want = awaited_matches.pop_front();
					if (best_index !== want.index) begin
						$display("%0t: best_index expected %0d actual %0d",
							$time, want.index, best_index);
						fail_count++;
					end
					if (exact_match !== want.exact) begin
						$display("%0t: exact_match expected %0d actual %0d",
							$time, want.exact, exact_match);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				c = '{red: red, green: green, blue: blue};
				if (mode == MODE_WRITE)
					palette_copy[entry_index] = c;
				else
					awaited_matches.push_back(nearest_match(c));
			end
			pending = awaited_matches.size();
		end
	end

endmodule

[dv/testbench.sv]
// Top of the palette search bench: clock, reset, beat stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench
	import npc_pkg::*;
();

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [INDEX_W-1:0] entry_index;
	logic [COMP_W-1:0]  red;
	logic [COMP_W-1:0]  green;
	logic [COMP_W-1:0]  blue;
	logic               out_valid;
	logic               out_stall;
	logic [INDEX_W-1:0] best_index;
	logic               exact_match;
	int                 fail_count;
	int                 pending;

	color_t loaded_colors [PALETTE_ENTRIES];
	logic   hold_request;
	int     burst_left;

	nearest_palette_color uut (.*);
	palette_match_monitor match_monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// gaps: mostly short, a few long, with bursts of back-to-back beats
	function automatic int pick_gap();
		int p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(99);
		if (p < 4) begin
			burst_left = $urandom_range(60, 20);
			return 0;
		end
		if (p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(3, 1);
		if (p < 98)
			return $urandom_range(20, 4);
		return $urandom_range(300, 40);
	endfunction

	task automatic send_beat(logic m, logic [INDEX_W-1:0] idx, color_t c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		entry_index <= idx;
		red         <= c.red;
		green       <= c.green;
		blue        <= c.blue;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_entry(int idx, color_t c);
		loaded_colors[idx] = c;
		send_beat(MODE_WRITE, INDEX_W'(idx), c);
	endtask

	task automatic query_color(color_t c);
		send_beat(MODE_QUERY, INDEX_W'($urandom_range(255)), c);
	endtask

	function automatic color_t theme_color(int theme);
		color_t c;
		case (theme)
			1: begin
				c.red   = COMP_W'($urandom_range(255, 190));
				c.green = COMP_W'($urandom_range(255, 190));
				c.blue  = COMP_W'($urandom_range(255, 190));
			end
			2: begin
				// few distinct levels, so equal distances are common
				c.red   = COMP_W'(85 * $urandom_range(3));
				c.green = COMP_W'(85 * $urandom_range(3));
				c.blue  = COMP_W'(85 * $urandom_range(3));
			end
			default: c = color_t'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] v);
		int x;
		x = int'(v) + $urandom_range(6) - 3;
		if (x < 0)
			x = 0;
		if (x > 255)
			x = 255;
		return COMP_W'(x);
	endfunction

	function automatic color_t pick_query(int theme);
		color_t c;
		int p;
		p = $urandom_range(99);
		if (p < 30) begin
			c = loaded_colors[$urandom_range(PALETTE_ENTRIES - 1)];
		end else if (p < 50) begin
			c = loaded_colors[$urandom_range(PALETTE_ENTRIES - 1)];
			c = '{red: nudge(c.red), green: nudge(c.green), blue: nudge(c.blue)};
		end else if (p < 58) begin
			c = '0;
		end else if (p < 63) begin
			c = '1;
		end else if (p < 73) begin
			c.red   = COMP_W'($urandom_range(40));
			c.green = COMP_W'($urandom_range(40));
			c.blue  = COMP_W'($urandom_range(40));
		end else if (p < 85) begin
			c = theme_color(theme);
		end else begin
			c = color_t'($urandom);
		end
		return c;
	endfunction

	task automatic mixed_items(int count, int theme);
		color_t c;
		int idx;
		repeat (count) begin
			if ($urandom_range(99) < 45) begin
				query_color(pick_query(theme));
			end else begin
				idx = $urandom_range(PALETTE_ENTRIES - 1);
				if ($urandom_range(99) < 20)
					c = loaded_colors[$urandom_range(PALETTE_ENTRIES - 1)];
				else
					c = theme_color(theme);
				write_entry(idx, c);
			end
		end
	endtask

	task automatic reload_palette(int theme, logic descending);
		int idx;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			idx = descending ? PALETTE_ENTRIES - 1 - i : i;
			write_entry(idx, theme_color(theme));
			// keep some queries in flight while the palette turns over
			if ($urandom_range(99) < 3)
				query_color(pick_query(theme));
		end
	endtask

	initial begin
		color_t c;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_WRITE;
		entry_index  = '0;
		red          = '0;
		green        = '0;
		blue         = '0;
		hold_request = 1'b0;
		burst_left   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every entry is loaded before the first query
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			if (i == 0)
				c = '0;
			else if (i == PALETTE_ENTRIES - 1)
				c = '1;
			else if (i == 20)
				c = loaded_colors[10];
			else if (i == 128)
				c = '{red: 8'hff, green: 8'h00, blue: 8'h00};
			else
				c = color_t'($urandom);
			write_entry(i, c);
		end

		query_color('0);
		query_color('1);
		query_color(loaded_colors[20]);  // duplicate entry: lower index wins
		query_color('{red: 8'hff, green: 8'h00, blue: 8'h00});
		query_color('{red: 8'h00, green: 8'hff, blue: 8'h00});
		query_color('{red: 8'h00, green: 8'h00, blue: 8'hff});
		query_color('{red: 8'h01, green: 8'h00, blue: 8'h00});
		query_color('{red: 8'hfe, green: 8'hff, blue: 8'hff});
		// entry 0 not black: a black query still falls back to entry 0
		write_entry(0, '{red: 8'h01, green: 8'h01, blue: 8'h01});
		query_color('0);
		query_color('{red: 8'h01, green: 8'h01, blue: 8'h01});
		write_entry(0, '1);
		query_color('0);
		query_color('1);
		write_entry(0, '0);
		query_color(loaded_colors[$urandom_range(PALETTE_ENTRIES - 1)]);

		hold_request = 1'b1;
		mixed_items(250, 0);
		reload_palette(1, 1'b1);
		mixed_items(200, 1);
		reload_palette(2, 1'b0);
		mixed_items(200, 2);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (PALETTE_ENTRIES + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// result side stalls, plus one long hold-off so the block backs up its input
	initial begin
		int p;
		int run;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (1500) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				p = $urandom_range(99);
				if (p < 45) begin
					out_stall <= 1'b0;
					run = $urandom_range(30, 1);
				end else begin
					out_stall <= 1'b1;
					if (p < 85)
						run = $urandom_range(3, 1);
					else if (p < 97)
						run = $urandom_range(20, 4);
					else
						run = $urandom_range(300, 40);
				end
				repeat (run - 1) @(negedge clk);
			end
		end
	end

endmodule
